// File: sv/complex_rpn_stack_alu_assert.svh
// Assertion macros used by the checker file of the complex stack calculator.
`ifndef COMPLEX_RPN_STACK_ALU_ASSERT_SVH
`define COMPLEX_RPN_STACK_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/crsalu_pkg.sv
// Package with the codes, widths and saturation helpers of the complex stack calculator.
package crsalu_pkg;

    localparam int W      = 32;
    localparam int NUM_W  = 64;
    localparam int ACC_W  = 66;
    localparam int MODE_W = 3;
    localparam int ERR_W  = 3;
    localparam int DEPTH_W = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_FEW   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_SAT   = 3'd4;

    // Request to the multiply-accumulate unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_mac_req;

    // Saturate a sign and magnitude pair to 32 bits; the top bit flags saturation.
    function automatic logic [W:0] sat_mag(input logic neg, input logic [ACC_W-1:0] mag);
        logic [W:0] res;
        if (!neg) begin
            if (mag > ACC_W'(32'h7FFF_FFFF)) res = {1'b1, 32'h7FFF_FFFF};
            else                             res = {1'b0, mag[W-1:0]};
        end else begin
            if (mag > ACC_W'(32'h8000_0000)) res = {1'b1, 32'h8000_0000};
            else                             res = {1'b0, -mag[W-1:0]};
        end
        return res;
    endfunction

    // Saturate a 33-bit signed sum to 32 bits; the top bit flags saturation.
    function automatic logic [W:0] sat_sum(input logic [W:0] s);
        logic [W:0] res;
        if (s[W] != s[W-1]) res = {1'b1, s[W] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        else                res = {1'b0, s[W-1:0]};
        return res;
    endfunction

    // Magnitude of a signed accumulator value.
    function automatic logic [ACC_W-1:0] abs_acc(input logic [ACC_W-1:0] a);
        return a[ACC_W-1] ? -a : a;
    endfunction

endpackage

// File: sv/crsalu_if.sv
// Request and result channel interfaces of the complex stack calculator.
interface crsalu_in_if;
    import crsalu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [W-1:0]      operand_real;
    logic signed [W-1:0]      operand_imag;
    modport source (output valid, mode, operand_real, operand_imag, input ready);
    modport sink   (input valid, mode, operand_real, operand_imag, output ready);
endinterface

interface crsalu_out_if;
    import crsalu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [W-1:0]      top_real;
    logic signed [W-1:0]      top_imag;
    logic [DEPTH_W-1:0]       depth;
    logic [ERR_W-1:0]         error;
    modport source (output valid, top_real, top_imag, depth, error, input ready);
    modport sink   (input valid, top_real, top_imag, depth, error, output ready);
endinterface

// File: sv/crsalu_ram.sv
// Generic single-port RAM with registered read.
module crsalu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read share the one address.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: sv/crsalu_mac.sv
// Bit-serial multiply-accumulate unit with three lanes for complex products.
module crsalu_mac
    import crsalu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_req                i_req,
    input  logic signed [W-1:0]     i_ar,
    input  logic signed [W-1:0]     i_ai,
    input  logic signed [W-1:0]     i_br,
    input  logic signed [W-1:0]     i_bi,
    output logic                    o_done,
    output logic [ACC_W-1:0]        o_acc0,
    output logic [ACC_W-1:0]        o_acc1,
    output logic [ACC_W-1:0]        o_acc2
);
    localparam int CNT_W = $clog2(W);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_is_div, n_is_div;
    logic [W-1:0]           r_ar, n_ar, r_ai, n_ai, r_br, n_br, r_bi, n_bi;
    logic [W-1:0]           r_brsh, n_brsh, r_bish, n_bish;
    logic [ACC_W-1:0]       r_acc0, n_acc0, r_acc1, n_acc1, r_acc2, n_acc2;

    // One Horner step: twice the sum plus the selected partial terms.
    function automatic logic [ACC_W-1:0] lane(input logic [ACC_W-1:0] acc,
                                              input logic b0, input logic b1,
                                              input logic [W-1:0] p,
                                              input logic [W-1:0] q,
                                              input logic sub, input logic msb);
        logic [W+1:0] pe, qe, t;
        pe = {{2{p[W-1]}}, p};
        qe = {{2{q[W-1]}}, q};
        t  = (b0 ? pe : '0) + (b1 ? (sub ? -qe : qe) : '0);
        if (msb) t = -t;
        return {acc[ACC_W-2:0], 1'b0} + {{(ACC_W-W-2){t[W+1]}}, t};
    endfunction

    // Load on a request, then one multiplier bit per cycle from the top down.
    always_comb begin
        n_busy = r_busy; n_done = 1'b0; n_cnt = r_cnt; n_is_div = r_is_div;
        n_ar = r_ar; n_ai = r_ai; n_br = r_br; n_bi = r_bi;
        n_brsh = r_brsh; n_bish = r_bish;
        n_acc0 = r_acc0; n_acc1 = r_acc1; n_acc2 = r_acc2;
        if (i_req.start) begin
            n_busy = 1'b1; n_cnt = '0; n_is_div = i_req.is_div;
            n_ar = i_ar; n_ai = i_ai; n_br = i_br; n_bi = i_bi;
            n_brsh = i_br; n_bish = i_bi;
            n_acc0 = '0; n_acc1 = '0; n_acc2 = '0;
        end else if (r_busy) begin
            n_acc0 = lane(r_acc0, r_brsh[W-1], r_bish[W-1], r_ar, r_ai, !r_is_div, r_cnt == '0);
            n_acc1 = lane(r_acc1, r_brsh[W-1], r_bish[W-1], r_ai, r_ar, r_is_div, r_cnt == '0);
            n_acc2 = lane(r_acc2, r_brsh[W-1], r_bish[W-1], r_br, r_bi, 1'b0, r_cnt == '0);
            n_brsh = {r_brsh[W-2:0], 1'b0};
            n_bish = {r_bish[W-2:0], 1'b0};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_is_div <= n_is_div;
        r_ar <= n_ar; r_ai <= n_ai; r_br <= n_br; r_bi <= n_bi;
        r_brsh <= n_brsh; r_bish <= n_bish;
        r_acc0 <= n_acc0; r_acc1 <= n_acc1; r_acc2 <= n_acc2;
    end

    assign o_done = r_done;
    assign o_acc0 = r_acc0;
    assign o_acc1 = r_acc1;
    assign o_acc2 = r_acc2;
endmodule

// File: sv/crsalu_div.sv
// Radix-2 restoring divider for scaled quotients with an overflow flag.
module crsalu_div
    import crsalu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [NUM_W-1:0]  i_den,
    output logic              o_done,
    output logic [W:0]        o_quot,
    output logic              o_ovf
);
    localparam int STEPS = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic               r_busy, n_busy, r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [NUM_W-1:0]   r_num, n_num, r_den, n_den;
    logic [NUM_W:0]     r_rem, n_rem;
    logic [W:0]         r_q, n_q;
    logic               r_ovf, n_ovf;
    logic [NUM_W:0]     rem_sh;
    logic               ge;

    // Dividend bits enter one per cycle, followed by the fraction zeros.
    always_comb begin
        n_busy = r_busy; n_done = 1'b0; n_cnt = r_cnt;
        n_num = r_num; n_den = r_den; n_rem = r_rem; n_q = r_q; n_ovf = r_ovf;
        rem_sh = {r_rem[NUM_W-1:0], r_num[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1; n_cnt = '0; n_num = i_num; n_den = i_den;
            n_rem = '0; n_q = '0; n_ovf = 1'b0;
        end else if (r_busy) begin
            n_rem = ge ? rem_sh - {1'b0, r_den} : rem_sh;
            n_q   = {r_q[W-1:0], ge};
            n_ovf = r_ovf | r_q[W];
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_num <= n_num; r_den <= n_den;
        r_rem <= n_rem; r_q <= n_q; r_ovf <= n_ovf;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_ovf  = r_ovf;
endmodule

// File: sv/complex_rpn_stack_alu.sv
// Top level of the complex number stack calculator.
// Stack of complex Q-format numbers with a saturating arithmetic unit. The top entry lives
// in registers and the entries below it in a single-port RAM, so a request touches the RAM
// at most once. One request is in work at a time and its result is held until taken. Push,
// clear and the unused modes go from the request straight to the result; add and subtract
// compute in the load step; multiply runs the bit-serial multiply-accumulate unit at one
// cycle per multiplier bit; and divide runs it and then the restoring divider, which yields
// one quotient bit per cycle. Errors leave the stack unchanged, except saturation, which
// stores the clipped result.
module complex_rpn_stack_alu
    import crsalu_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crsalu_in_if.sink    i_req,
    crsalu_out_if.source o_rsp
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MAC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [ERR_W-1:0]   r_err, n_err;
    logic [W-1:0]       r_top_re, n_top_re, r_top_im, n_top_im;
    logic               r_re_neg, n_re_neg, r_im_neg, n_im_neg;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [2*W-1:0]     ram_rdata;
    logic [W-1:0]       b_re, b_im;
    t_mac_req           mac_req;
    logic               mac_done;
    logic [ACC_W-1:0]   acc0, acc1, acc2;
    logic [ACC_W-1:0]   num_re, num_im;
    logic               div_start, div_done, div_done_im;
    logic [W:0]         q_re, q_im;
    logic               ovf_re, ovf_im;
    logic [W:0]         sat_re, sat_im;
    logic [ACC_W-1:0]   mag_re, mag_im;

    crsalu_ram #(.WIDTH(2 * W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata({r_top_re, r_top_im}), .o_rdata(ram_rdata)
    );

    crsalu_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mac_req),
        .i_ar(r_top_re), .i_ai(r_top_im), .i_br(b_re), .i_bi(b_im),
        .o_done(mac_done), .o_acc0(acc0), .o_acc1(acc1), .o_acc2(acc2)
    );

    // Numerator magnitudes for the two dividers.
    assign num_re = abs_acc(acc0);
    assign num_im = abs_acc(acc1);

    crsalu_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_re[NUM_W-1:0]), .i_den(acc2[NUM_W-1:0]),
        .o_done(div_done), .o_quot(q_re), .o_ovf(ovf_re)
    );

    crsalu_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_im[NUM_W-1:0]), .i_den(acc2[NUM_W-1:0]),
        .o_done(div_done_im), .o_quot(q_im), .o_ovf(ovf_im)
    );

    assign b_re = ram_rdata[2*W-1:W];
    assign b_im = ram_rdata[W-1:0];

    // Request sequencing and stack update.
    always_comb begin
        n_state = r_state; n_count = r_count; n_mode = r_mode; n_err = r_err;
        n_top_re = r_top_re; n_top_im = r_top_im;
        n_re_neg = r_re_neg; n_im_neg = r_im_neg;
        ram_we = 1'b0;
        ram_addr = AW'(r_count - CW'(2));
        mac_req = '0;
        div_start = 1'b0;
        sat_re = '0; sat_im = '0; mag_re = '0; mag_im = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.mode == MODE_PUSH) ram_addr = AW'(r_count - CW'(1));
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_err   = ERR_OK;
                    n_state = S_OUT;
                    case (i_req.mode)
                        MODE_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                n_err = ERR_FULL;
                            end else begin
                                ram_we   = (r_count != '0);
                                n_top_re = i_req.operand_real;
                                n_top_im = i_req.operand_imag;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                            if (r_count < CW'(2)) n_err = ERR_FEW;
                            else                  n_state = S_LOAD;
                        end
                        MODE_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_OUT;
                case (r_mode)
                    MODE_ADD, MODE_SUB: begin
                        if (r_mode == MODE_ADD) begin
                            sat_re = sat_sum({r_top_re[W-1], r_top_re} + {b_re[W-1], b_re});
                            sat_im = sat_sum({r_top_im[W-1], r_top_im} + {b_im[W-1], b_im});
                        end else begin
                            sat_re = sat_sum({r_top_re[W-1], r_top_re} - {b_re[W-1], b_re});
                            sat_im = sat_sum({r_top_im[W-1], r_top_im} - {b_im[W-1], b_im});
                        end
                        n_top_re = sat_re[W-1:0];
                        n_top_im = sat_im[W-1:0];
                        n_count  = r_count - CW'(1);
                        if (sat_re[W] || sat_im[W]) n_err = ERR_SAT;
                    end
                    MODE_DIV: begin
                        if (b_re == '0 && b_im == '0) begin
                            n_err = ERR_DIV0;
                        end else begin
                            mac_req = '{start: 1'b1, is_div: 1'b1};
                            n_state = S_MAC;
                        end
                    end
                    default: begin
                        mac_req = '{start: 1'b1, is_div: 1'b0};
                        n_state = S_MAC;
                    end
                endcase
            end
            S_MAC: begin
                if (mac_done) begin
                    if (r_mode == MODE_MUL) begin
                        mag_re   = abs_acc(acc0) >> FRAC_BITS;
                        mag_im   = abs_acc(acc1) >> FRAC_BITS;
                        sat_re   = sat_mag(acc0[ACC_W-1], mag_re);
                        sat_im   = sat_mag(acc1[ACC_W-1], mag_im);
                        n_top_re = sat_re[W-1:0];
                        n_top_im = sat_im[W-1:0];
                        n_count  = r_count - CW'(1);
                        if (sat_re[W] || sat_im[W]) n_err = ERR_SAT;
                        n_state  = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_re_neg  = acc0[ACC_W-1];
                        n_im_neg  = acc1[ACC_W-1];
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done && div_done_im) begin
                    mag_re   = ACC_W'({ovf_re, q_re});
                    mag_im   = ACC_W'({ovf_im, q_im});
                    sat_re   = sat_mag(r_re_neg, mag_re);
                    sat_im   = sat_mag(r_im_neg, mag_im);
                    n_top_re = sat_re[W-1:0];
                    n_top_im = sat_im[W-1:0];
                    n_count  = r_count - CW'(1);
                    if (sat_re[W] || sat_im[W]) n_err = ERR_SAT;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_mode <= n_mode; r_err <= n_err;
        r_top_re <= n_top_re; r_top_im <= n_top_im;
        r_re_neg <= n_re_neg; r_im_neg <= n_im_neg;
    end

    // Result channel reads straight from the held state.
    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = (r_state == S_OUT);
    assign o_rsp.top_real = (r_count != '0) ? r_top_re : '0;
    assign o_rsp.top_imag = (r_count != '0) ? r_top_im : '0;
    assign o_rsp.depth    = DEPTH_W'(r_count);
    assign o_rsp.error    = r_err;
endmodule

// File: sv/crsalu_chk.sv
// Port-level checker for the complex stack calculator, bound to the top level.
`include "complex_rpn_stack_alu_assert.svh"

module crsalu_chk
    import crsalu_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [W-1:0]        i_top_real,
    input logic [W-1:0]        i_top_imag,
    input logic [DEPTH_W-1:0]  i_depth,
    input logic [ERR_W-1:0]    i_error
);
    // A request in work blocks the next one.
    `CRS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request accepted while busy")
    // An empty stack shows a zero top.
    `CRS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_depth == '0, i_top_real == '0 && i_top_imag == '0, "empty stack shows nonzero top")
    // A full-stack error only happens at the full depth.
    `CRS_ASSERT_NOW(a_full_depth, i_clk, i_rst_n, i_out_valid && i_error == ERR_FULL, i_depth == DEPTH_W'(STACK_DEPTH), "stack full reported below full depth")
    // Too few operands means fewer than two entries are left.
    `CRS_ASSERT_NOW(a_few_depth, i_clk, i_rst_n, i_out_valid && i_error == ERR_FEW, i_depth == DEPTH_W'(0) || i_depth == DEPTH_W'(1), "too few operands with two or more entries")
    // A stalled result holds.
    `CRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_top_real) && $stable(i_top_imag) && $stable(i_depth) && $stable(i_error), "stalled result changed")
endmodule

bind complex_rpn_stack_alu crsalu_chk #(.STACK_DEPTH(STACK_DEPTH)) u_crsalu_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
    .i_top_real(o_rsp.top_real), .i_top_imag(o_rsp.top_imag),
    .i_depth(o_rsp.depth), .i_error(o_rsp.error)
);
